// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, idle while reset is asserted
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/wpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared widths, constants, types and state encodings of the level meter.
// ----------------------------------------------------------------------------
package wpm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WINDOW_BITS = 20;

    localparam int MAG_W    = SAMPLE_BITS + 1;
    localparam int CNT_W    = WINDOW_BITS + 1;
    localparam int SUM_W    = 2 * (SAMPLE_BITS - 1) + WINDOW_BITS + 1;
    localparam int LVL_W    = 17;
    localparam int EXP_W    = $clog2(SUM_W);
    localparam int FRAC_W   = 16;
    localparam int LOG_W    = EXP_W + FRAC_W;
    localparam int MANT_W   = 32;
    localparam int D_W      = LOG_W + 2;
    localparam int K_W      = 27;
    localparam int PROD_W   = K_W + D_W;
    localparam int SQ_W     = 32;
    localparam int SQ_ITERS = SQ_W / 2;
    localparam int SQ_CNT_W = $clog2(SQ_ITERS);
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);
    localparam int FRAC_CNT_W = $clog2(FRAC_W);
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [K_W-1:0]   LOG_K     = K_W'(101008905);
    localparam logic [15:0]      DB_FLOOR  = 16'd30720;
    localparam logic [LVL_W-1:0] LVL_FLOOR = LVL_W'(-30720);
    localparam logic [D_W-1:0]   PEAK_OFF  = D_W'((SAMPLE_BITS - 1) * 65536);
    localparam logic [D_W-1:0]   RMS_OFF   = D_W'(2 * (SAMPLE_BITS - 1) * 65536);
    localparam logic [WINDOW_BITS-1:0] WL_RESET = WINDOW_BITS'(1024);

    localparam logic [ADDR_W-3:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [ADDR_W-3:0] REG_LOG_SCALE     = 1'b1;

    typedef struct packed {
        logic [MAG_W-1:0] pos_peak;
        logic [MAG_W-1:0] neg_peak;
        logic [SUM_W-1:0] pos_sum;
        logic [SUM_W-1:0] neg_sum;
        logic [CNT_W-1:0] pos_cnt;
        logic [CNT_W-1:0] neg_cnt;
        logic             log_scale;
    } snap_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] value;
    } log_req_t;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] result;
    } log_rsp_t;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQ,
        LG_DONE
    } lg_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SEL,
        BK_LOGA,
        BK_LOGB,
        BK_DBMUL,
        BK_DBFIN,
        BK_DIV,
        BK_SQRT,
        BK_NEXT,
        BK_EMIT
    } back_state_t;

endpackage

// ===== hdl/windowed_peak_rms_meter_core.sv =====
// ----------------------------------------------------------------------------
// windowed_peak_rms_meter_core
// Windowed peak and RMS level meter, linear Q1.15 or Q7.8 dB levels.
// ----------------------------------------------------------------------------
//  channel  | direction | beat
//  s_       | in        | one Q1.15 sample
//  m_       | out       | four levels of one finished window
//  apb      | in        | window_length at 0x0, log_scale at 0x4
//
//  Front end takes one sample per cycle while s_ready is high; a snapshot
//  is queued at window end. Back end per window: log2 normalise plus 16
//  squaring steps per log, or a divide plus square root per RMS level.
//  Two queued windows before s_ready drops.
//  Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module windowed_peak_rms_meter_core import wpm_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [LVL_W-1:0] m_pos_peak_level,
    output logic signed [LVL_W-1:0] m_neg_peak_level,
    output logic signed [LVL_W-1:0] m_pos_rms_level,
    output logic signed [LVL_W-1:0] m_neg_rms_level,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    logic [WINDOW_BITS-1:0] wl_reg;
    logic                   ls_reg;
    logic                   wr_en;
    logic [ADDR_W-3:0]      reg_idx;

    logic     q_push, q_pop, q_full, q_empty;
    snap_t    q_snap, q_head;
    log_req_t lg_req;
    log_rsp_t lg_rsp;
    logic [LVL_W-1:0] pp, np, pr, nr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        unique case (reg_idx)
            REG_WINDOW_LENGTH: prdata = DATA_W'(wl_reg);
            REG_LOG_SCALE:     prdata = DATA_W'(ls_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg <= WL_RESET;
            ls_reg <= 1'b0;
        end else if (wr_en) begin
            if (reg_idx == REG_WINDOW_LENGTH) begin
                wl_reg <= pwdata[WINDOW_BITS-1:0];
            end
            if (reg_idx == REG_LOG_SCALE) begin
                ls_reg <= pwdata[0];
            end
        end
    end

    wpm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .window_length (wl_reg),
        .log_scale     (ls_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_snap        (q_snap)
    );

    wpm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_snap (q_snap),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    wpm_log2 u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (lg_req),
        .rsp     (lg_rsp)
    );

    wpm_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_empty          (q_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .lg_req           (lg_req),
        .lg_rsp           (lg_rsp),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pos_peak_level (pp),
        .m_neg_peak_level (np),
        .m_pos_rms_level  (pr),
        .m_neg_rms_level  (nr)
    );

    assign m_pos_peak_level = pp;
    assign m_neg_peak_level = np;
    assign m_pos_rms_level  = pr;
    assign m_neg_rms_level  = nr;

endmodule

// ===== hdl/wpm_front.sv =====
// ----------------------------------------------------------------------------
// wpm_front
// Per-sample accumulation of peaks, square sums and counts; hands a snapshot
// to the queue at the end of each window.
// ----------------------------------------------------------------------------
module wpm_front import wpm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    input  logic [WINDOW_BITS-1:0] window_length,
    input  logic                   log_scale,
    input  logic                   q_full,
    output logic                   q_push,
    output snap_t                  q_snap
);

    logic [WINDOW_BITS-1:0] pos_reg;
    logic [MAG_W-1:0]       pos_peak_reg, neg_peak_reg;
    logic [SUM_W-1:0]       pos_sum_reg, neg_sum_reg;
    logic [CNT_W-1:0]       pos_cnt_reg, neg_cnt_reg;

    logic [MAG_W-1:0]       pos_peak_next, neg_peak_next;
    logic [SUM_W-1:0]       pos_sum_next, neg_sum_next;
    logic [CNT_W-1:0]       pos_cnt_next, neg_cnt_next;

    logic                   acc;
    logic                   is_neg;
    logic                   is_zero;
    logic [MAG_W-1:0]       mag;
    logic [2*MAG_W-1:0]     sq;
    logic [WINDOW_BITS:0]   newpos;
    logic                   win_end;

    assign s_ready = !q_full;
    assign acc     = s_valid && s_ready && (window_length != '0);
    assign is_neg  = s_sample[SAMPLE_BITS-1];
    assign is_zero = (s_sample == '0);
    assign mag     = is_neg ? ((MAG_W'(1) << SAMPLE_BITS) - {1'b0, s_sample})
                            : {1'b0, s_sample};
    assign sq      = mag * mag;
    assign newpos  = {1'b0, pos_reg} + 1'b1;
    assign win_end = newpos >= {1'b0, window_length};

    always_comb begin
        pos_peak_next = pos_peak_reg;
        neg_peak_next = neg_peak_reg;
        pos_sum_next  = pos_sum_reg;
        neg_sum_next  = neg_sum_reg;
        pos_cnt_next  = pos_cnt_reg;
        neg_cnt_next  = neg_cnt_reg;
        if (is_neg) begin
            if (mag > neg_peak_reg) begin
                neg_peak_next = mag;
            end
            neg_sum_next = neg_sum_reg + SUM_W'(sq);
            neg_cnt_next = neg_cnt_reg + 1'b1;
        end else if (!is_zero) begin
            if (mag > pos_peak_reg) begin
                pos_peak_next = mag;
            end
            pos_sum_next = pos_sum_reg + SUM_W'(sq);
            pos_cnt_next = pos_cnt_reg + 1'b1;
        end else begin
            neg_cnt_next = neg_cnt_reg + 1'b1;
        end
    end

    assign q_push = acc && win_end;

    always_comb begin
        q_snap.pos_peak  = pos_peak_next;
        q_snap.neg_peak  = neg_peak_next;
        q_snap.pos_sum   = pos_sum_next;
        q_snap.neg_sum   = neg_sum_next;
        q_snap.pos_cnt   = pos_cnt_next;
        q_snap.neg_cnt   = neg_cnt_next;
        q_snap.log_scale = log_scale;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            pos_peak_reg <= '0;
            neg_peak_reg <= '0;
            pos_sum_reg  <= '0;
            neg_sum_reg  <= '0;
            pos_cnt_reg  <= '0;
            neg_cnt_reg  <= '0;
        end else if (acc) begin
            if (win_end) begin
                pos_reg      <= '0;
                pos_peak_reg <= '0;
                neg_peak_reg <= '0;
                pos_sum_reg  <= '0;
                neg_sum_reg  <= '0;
                pos_cnt_reg  <= '0;
                neg_cnt_reg  <= '0;
            end else begin
                pos_reg      <= newpos[WINDOW_BITS-1:0];
                pos_peak_reg <= pos_peak_next;
                neg_peak_reg <= neg_peak_next;
                pos_sum_reg  <= pos_sum_next;
                neg_sum_reg  <= neg_sum_next;
                pos_cnt_reg  <= pos_cnt_next;
                neg_cnt_reg  <= neg_cnt_next;
            end
        end
    end

endmodule

// ===== hdl/wpm_queue.sv =====
// ----------------------------------------------------------------------------
// wpm_queue
// Two-entry queue of window snapshots between front and back end.
// ----------------------------------------------------------------------------
module wpm_queue import wpm_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  snap_t push_snap,
    input  logic  pop,
    output snap_t head,
    output logic  full,
    output logic  empty
);

    snap_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_snap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== hdl/wpm_log2.sv =====
// ----------------------------------------------------------------------------
// wpm_log2
// Iterative log2 in Q.16: one-bit-a-cycle normalisation, then sixteen
// squaring steps of the mantissa.
// ----------------------------------------------------------------------------
module wpm_log2 import wpm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  log_req_t req,
    output log_rsp_t rsp
);

    lg_state_t              st_reg, st_next;
    logic [SUM_W-1:0]       x_reg;
    logic [EXP_W-1:0]       exp_reg;
    logic [MANT_W-1:0]      m_reg;
    logic [FRAC_W-1:0]      frac_reg;
    logic [FRAC_CNT_W-1:0]  it_reg;
    logic [2*MANT_W-1:0]    prod;
    logic [MANT_W:0]        t;

    assign prod = m_reg * m_reg;
    assign t    = prod[2*MANT_W-1:MANT_W-1];

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            LG_IDLE: begin
                if (req.start) begin
                    st_next = LG_NORM;
                end
            end
            LG_NORM: begin
                if (x_reg[SUM_W-1]) begin
                    st_next = LG_SQ;
                end
            end
            LG_SQ: begin
                if (it_reg == '0) begin
                    st_next = LG_DONE;
                end
            end
            LG_DONE: st_next = req.start ? LG_NORM : LG_IDLE;
            default: st_next = LG_IDLE;
        endcase
    end

    always_comb begin
        rsp.done   = (st_reg == LG_DONE);
        rsp.result = {exp_reg, frac_reg};
    end

    always_ff @(posedge aclk) begin
        unique case (st_reg)
            LG_IDLE, LG_DONE: begin
                x_reg    <= req.value;
                exp_reg  <= EXP_W'(SUM_W - 1);
                frac_reg <= '0;
            end
            LG_NORM: begin
                if (x_reg[SUM_W-1]) begin
                    m_reg  <= x_reg[SUM_W-1 -: MANT_W];
                    it_reg <= FRAC_CNT_W'(FRAC_W - 1);
                end else begin
                    x_reg   <= {x_reg[SUM_W-2:0], 1'b0};
                    exp_reg <= exp_reg - 1'b1;
                end
            end
            LG_SQ: begin
                if (t[MANT_W]) begin
                    m_reg            <= t[MANT_W:1];
                    frac_reg[it_reg] <= 1'b1;
                end else begin
                    m_reg <= t[MANT_W-1:0];
                end
                it_reg <= it_reg - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= LG_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== hdl/wpm_back.sv =====
// ----------------------------------------------------------------------------
// wpm_back
// Per-window level computation: shared log2 unit, dB scaling, restoring
// divider and bit-serial square root; holds the result beat.
// ----------------------------------------------------------------------------
module wpm_back import wpm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  snap_t            q_head,
    output logic             q_pop,
    output log_req_t         lg_req,
    input  log_rsp_t         lg_rsp,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [LVL_W-1:0] m_pos_peak_level,
    output logic [LVL_W-1:0] m_neg_peak_level,
    output logic [LVL_W-1:0] m_pos_rms_level,
    output logic [LVL_W-1:0] m_neg_rms_level
);

    back_state_t            st_reg, st_next;
    snap_t                  snap_reg;
    logic [1:0]             idx_reg;
    logic [LOG_W-1:0]       la_reg;
    logic [D_W-1:0]         d_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [SUM_W-1:0]       q_reg;
    logic [CNT_W:0]         rem_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [SQ_W-1:0]        sx_reg, sr_reg, sbit_reg;
    logic [SQ_CNT_W-1:0]    sq_cnt_reg;
    logic [LVL_W-1:0]       lvl_reg [4];
    logic                   m_valid_reg;
    logic [LVL_W-1:0]       out_reg [4];

    logic                   rms_side;
    logic [MAG_W-1:0]       pk;
    logic [SUM_W-1:0]       sum;
    logic [CNT_W-1:0]       cnt;
    logic                   lg_mode;
    logic [D_W-1:0]         d_peak, d_rms, d_abs;
    logic [CNT_W:0]         rem_sh;
    logic                   rem_ge;
    logic [SUM_W-1:0]       q_next;
    logic [SQ_W:0]          s_try;
    logic                   s_ge;
    logic [SQ_W-1:0]        sr_next, sx_next;
    logic [PROD_W:0]        rnd_sum;
    logic [PROD_W:0]        v;
    logic [15:0]            v_clamp;
    logic                   lvl_we;
    logic [LVL_W-1:0]       lvl_wd;
    logic                   emit;

    assign rms_side = idx_reg[1];
    assign pk       = idx_reg[0] ? snap_reg.neg_peak : snap_reg.pos_peak;
    assign sum      = idx_reg[0] ? snap_reg.neg_sum  : snap_reg.pos_sum;
    assign cnt      = idx_reg[0] ? snap_reg.neg_cnt  : snap_reg.pos_cnt;
    assign lg_mode  = snap_reg.log_scale;

    assign d_peak = {2'b00, lg_rsp.result} - PEAK_OFF;
    assign d_rms  = {2'b00, la_reg} - {2'b00, lg_rsp.result} - RMS_OFF;
    assign d_abs  = D_W'(0) - d_reg;

    assign rem_sh = {rem_reg[CNT_W-1:0], q_reg[SUM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, cnt};
    assign q_next = {q_reg[SUM_W-2:0], rem_ge};

    assign s_try   = {1'b0, sr_reg} + {1'b0, sbit_reg};
    assign s_ge    = {1'b0, sx_reg} >= s_try;
    assign sx_next = s_ge ? (sx_reg - s_try[SQ_W-1:0]) : sx_reg;
    assign sr_next = s_ge ? ((sr_reg >> 1) + sbit_reg) : (sr_reg >> 1);

    assign rnd_sum = {1'b0, prod_reg}
                   + (rms_side ? ((PROD_W+1)'(1) << 32) : ((PROD_W+1)'(1) << 31));
    assign v       = rms_side ? (rnd_sum >> 33) : (rnd_sum >> 32);
    assign v_clamp = (v > (PROD_W+1)'(DB_FLOOR)) ? DB_FLOOR : v[15:0];

    assign emit = (st_reg == BK_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    st_next = BK_SEL;
                end
            end
            BK_SEL: begin
                if (!rms_side) begin
                    st_next = (lg_mode && pk != '0) ? BK_LOGA : BK_NEXT;
                end else if (lg_mode) begin
                    st_next = (cnt == '0 || sum == '0) ? BK_NEXT : BK_LOGA;
                end else begin
                    st_next = (cnt == '0) ? BK_NEXT : BK_DIV;
                end
            end
            BK_LOGA: begin
                if (lg_rsp.done) begin
                    st_next = rms_side ? BK_LOGB : BK_DBMUL;
                end
            end
            BK_LOGB: begin
                if (lg_rsp.done) begin
                    st_next = BK_DBMUL;
                end
            end
            BK_DBMUL: st_next = d_reg[D_W-1] ? BK_DBFIN : BK_NEXT;
            BK_DBFIN: st_next = BK_NEXT;
            BK_DIV: begin
                if (div_cnt_reg == DIV_CNT_W'(SUM_W - 1)) begin
                    st_next = BK_SQRT;
                end
            end
            BK_SQRT: begin
                if (sq_cnt_reg == SQ_CNT_W'(SQ_ITERS - 1)) begin
                    st_next = BK_NEXT;
                end
            end
            BK_NEXT: st_next = (idx_reg == 2'd3) ? BK_EMIT : BK_SEL;
            BK_EMIT: begin
                if (emit) begin
                    st_next = BK_IDLE;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop        = 1'b0;
        lg_req.start = 1'b0;
        lg_req.value = sum;
        lvl_we       = 1'b0;
        lvl_wd       = '0;
        unique case (st_reg)
            BK_IDLE: q_pop = !q_empty;
            BK_SEL: begin
                if (!rms_side) begin
                    lg_req.value = SUM_W'(pk);
                    lg_req.start = lg_mode && (pk != '0);
                    lvl_we       = !(lg_mode && pk != '0);
                    lvl_wd       = lg_mode ? LVL_FLOOR : LVL_W'(pk);
                end else if (lg_mode) begin
                    lg_req.start = !(cnt == '0 || sum == '0);
                    lvl_we       = (cnt == '0 || sum == '0);
                    lvl_wd       = LVL_FLOOR;
                end else begin
                    lvl_we = (cnt == '0);
                end
            end
            BK_LOGA: begin
                lg_req.value = SUM_W'(cnt);
                lg_req.start = lg_rsp.done && rms_side;
            end
            BK_DBMUL: lvl_we = !d_reg[D_W-1];
            BK_DBFIN: begin
                lvl_we = 1'b1;
                lvl_wd = LVL_W'(0) - LVL_W'(v_clamp);
            end
            BK_SQRT: begin
                lvl_we = (sq_cnt_reg == SQ_CNT_W'(SQ_ITERS - 1));
                lvl_wd = sr_next[LVL_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            snap_reg <= q_head;
        end
        if (lvl_we) begin
            lvl_reg[idx_reg] <= lvl_wd;
        end
        unique case (st_reg)
            BK_SEL: begin
                q_reg       <= sum;
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            BK_LOGA: begin
                if (lg_rsp.done) begin
                    la_reg <= lg_rsp.result;
                    d_reg  <= d_peak;
                end
            end
            BK_LOGB: begin
                if (lg_rsp.done) begin
                    d_reg <= d_rms;
                end
            end
            BK_DBMUL: prod_reg <= LOG_K * d_abs;
            BK_DIV: begin
                q_reg       <= q_next;
                rem_reg     <= rem_ge ? (rem_sh - {1'b0, cnt}) : rem_sh;
                div_cnt_reg <= div_cnt_reg + 1'b1;
                sx_reg      <= q_next[SQ_W-1:0];
                sr_reg      <= '0;
                sbit_reg    <= SQ_W'(1) << (SQ_W - 2);
                sq_cnt_reg  <= '0;
            end
            BK_SQRT: begin
                sx_reg     <= sx_next;
                sr_reg     <= sr_next;
                sbit_reg   <= sbit_reg >> 2;
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            end
            default: begin
            end
        endcase
        if (emit) begin
            out_reg <= lvl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= BK_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == BK_IDLE) begin
                idx_reg <= '0;
            end else if (st_reg == BK_NEXT) begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pos_peak_level = out_reg[0];
    assign m_neg_peak_level = out_reg[1];
    assign m_pos_rms_level  = out_reg[2];
    assign m_neg_rms_level  = out_reg[3];

endmodule

// ===== hdl/wpm_checker.sv =====
// ----------------------------------------------------------------------------
// wpm_checker
// Port-level checks of the level meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wpm_checker import wpm_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [LVL_W-1:0] m_pos_peak_level,
    input logic signed [LVL_W-1:0] m_neg_peak_level,
    input logic signed [LVL_W-1:0] m_pos_rms_level,
    input logic signed [LVL_W-1:0] m_neg_rms_level
);

    `ASSERT_CLK(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_pos_rms_level), "result beat dropped or changed under stall")
    `ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `ASSERT_CLK(a_range, aclk, aresetn, m_valid |-> m_pos_peak_level >= -30720 && m_neg_peak_level >= -30720 && m_pos_rms_level >= -30720 && m_neg_rms_level >= -30720 && m_pos_rms_level <= 32768 && m_neg_rms_level <= 32768, "level out of range")

endmodule

bind windowed_peak_rms_meter_core wpm_checker u_wpm_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_pos_peak_level (m_pos_peak_level),
    .m_neg_peak_level (m_neg_peak_level),
    .m_pos_rms_level  (m_pos_rms_level),
    .m_neg_rms_level  (m_neg_rms_level)
);
